// File: hdl/ntft_pkg.sv
// ----------------------------------------------------------------------------
// ntft_pkg: shared types and constants for the nearest-time frame table
// widths, request and status codes, and the table write port bundle
// ----------------------------------------------------------------------------
package ntft_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int TIME_WIDTH    = 32;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);

    typedef logic [TIME_WIDTH-1:0]    t_time;
    typedef logic [PAYLOAD_WIDTH-1:0] t_pay;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;

    // request kinds
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic  en;
        t_addr addr;
        t_time time_val;
        t_pay  payload;
    } t_wr_req;

endpackage

// File: hdl/ntft_store.sv
// ----------------------------------------------------------------------------
// ntft_store: entry memory
// timestamp and payload arrays, one write port, one registered read port
// ----------------------------------------------------------------------------
module ntft_store (
    input  logic             i_clk,
    input  ntft_pkg::t_wr_req i_wr,
    input  logic             i_rd_en,
    input  ntft_pkg::t_addr  i_rd_addr,
    output ntft_pkg::t_time  o_rd_time,
    output ntft_pkg::t_pay   o_rd_payload
);
    import ntft_pkg::*;

    t_time r_time_mem [TABLE_DEPTH];
    t_pay  r_pay_mem  [TABLE_DEPTH];
    t_time r_rd_time;
    t_pay  r_rd_payload;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_time_mem[i_wr.addr] <= i_wr.time_val;
            r_pay_mem[i_wr.addr]  <= i_wr.payload;
        end
        if (i_rd_en) begin
            r_rd_time    <= r_time_mem[i_rd_addr];
            r_rd_payload <= r_pay_mem[i_rd_addr];
        end
    end

    assign o_rd_time    = r_rd_time;
    assign o_rd_payload = r_rd_payload;

endmodule

// File: hdl/ntft_cmp.sv
// ----------------------------------------------------------------------------
// ntft_cmp: shared compare unit
// unsigned less-than and absolute difference of two time words
// ----------------------------------------------------------------------------
module ntft_cmp (
    input  ntft_pkg::t_time i_a,
    input  ntft_pkg::t_time i_b,
    output logic            o_lt,
    output ntft_pkg::t_time o_diff
);
    import ntft_pkg::*;

    logic [TIME_WIDTH:0] w_sub;

    // borrow out of a - b means a < b
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_lt   = w_sub[TIME_WIDTH];
    assign o_diff = w_sub[TIME_WIDTH] ? (i_b - i_a) : w_sub[TIME_WIDTH-1:0];

endmodule

// File: hdl/nearest_time_frame_table.sv
// ----------------------------------------------------------------------------
// nearest_time_frame_table: time-ordered frame table with nearest lookup
// clear, append and nearest-time query over a table of up to 1024 entries
// ----------------------------------------------------------------------------
// One request beat in, one result beat out. Clear, append and the unused
// request code finish in the cycle they are accepted. A query runs a
// lower-bound binary search over the stored entries with one memory read
// and one pass through the shared compare unit per probe. When the query
// falls between two entries it then measures the distance to both
// candidates; in every case it reads the chosen entry back. The entry
// memory has a single read port and the compare unit is shared, so these
// steps run one after another. A new request is taken only while no query
// is in flight and the output register is empty or being drained in the
// same cycle. Entries are appended in order and are not checked; past the
// last entry the last is returned, at or before the first the first is
// returned, and a distance tie goes to the earlier entry.
// ----------------------------------------------------------------------------
module nearest_time_frame_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // time_value[31:0], entry_payload[63:32]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // found_time[31:0], found_payload[63:32],
                                       // entry_count[74:64], zero pad[79:75]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);
    import ntft_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PROBE    = 4'd1;
    localparam logic [3:0] S_CMP      = 4'd2;
    localparam logic [3:0] S_DIST_HI  = 4'd3;
    localparam logic [3:0] S_DIST_LO  = 4'd4;
    localparam logic [3:0] S_PICK     = 4'd5;
    localparam logic [3:0] S_READ_SEL = 4'd6;
    localparam logic [3:0] S_LOAD     = 4'd7;

    // request fields
    logic [1:0] w_req_type;
    t_time      w_time_value;
    t_pay       w_entry_payload;

    assign w_req_type      = s_axis_tuser;
    assign w_time_value    = s_axis_tdata[TIME_WIDTH-1:0];
    assign w_entry_payload = s_axis_tdata[TIME_WIDTH +: PAYLOAD_WIDTH];

    // control state
    logic [3:0] r_state, n_state;
    t_cnt       r_count, n_count;
    logic       r_out_valid, n_out_valid;

    // search datapath
    t_time r_q, n_q;
    t_cnt  r_first, n_first;
    t_cnt  r_len, n_len;
    t_cnt  r_half, n_half;
    t_cnt  r_sel, n_sel;
    t_time r_dist_hi, n_dist_hi;
    t_time r_dist_lo, n_dist_lo;

    // output register
    logic [1:0] r_out_status, n_out_status;
    t_time      r_out_time, n_out_time;
    t_pay       r_out_payload, n_out_payload;
    t_cnt       r_out_count, n_out_count;

    // memory and compare unit hookup
    t_wr_req w_wr;
    logic    w_rd_en;
    t_addr   w_rd_addr;
    t_time   w_rd_time;
    t_pay    w_rd_payload;
    t_time   w_cmp_a;
    t_time   w_cmp_b;
    logic    w_cmp_lt;
    t_time   w_cmp_diff;

    logic w_accept;
    t_cnt w_mid;
    t_cnt w_first_m1;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_mid      = r_first + (r_len >> 1);
    assign w_first_m1 = r_first - t_cnt'(1);

    ntft_store u_store (
        .i_clk        (i_clk),
        .i_wr         (w_wr),
        .i_rd_en      (w_rd_en),
        .i_rd_addr    (w_rd_addr),
        .o_rd_time    (w_rd_time),
        .o_rd_payload (w_rd_payload)
    );

    // distance compare uses the stored distances, everything else the read word
    assign w_cmp_a = (r_state == S_PICK) ? r_dist_hi : w_rd_time;
    assign w_cmp_b = (r_state == S_PICK) ? r_dist_lo : r_q;

    ntft_cmp u_cmp (
        .i_a    (w_cmp_a),
        .i_b    (w_cmp_b),
        .o_lt   (w_cmp_lt),
        .o_diff (w_cmp_diff)
    );

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_q           = r_q;
        n_first       = r_first;
        n_len         = r_len;
        n_half        = r_half;
        n_sel         = r_sel;
        n_dist_hi     = r_dist_hi;
        n_dist_lo     = r_dist_lo;
        n_out_status  = r_out_status;
        n_out_time    = r_out_time;
        n_out_payload = r_out_payload;
        n_out_count   = r_out_count;
        w_wr.en       = 1'b0;
        w_wr.addr     = r_count[ADDR_W-1:0];
        w_wr.time_val = w_time_value;
        w_wr.payload  = w_entry_payload;
        w_rd_en       = 1'b0;
        w_rd_addr     = w_mid[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // immediate result unless a search has to run
                    n_out_valid   = 1'b1;
                    n_out_status  = ST_OK;
                    n_out_time    = '0;
                    n_out_payload = '0;
                    n_out_count   = r_count;
                    case (w_req_type)
                        REQ_CLEAR: begin
                            n_count     = '0;
                            n_out_count = '0;
                        end
                        REQ_APPEND: begin
                            if (r_count >= t_cnt'(TABLE_DEPTH)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                w_wr.en     = 1'b1;
                                n_count     = r_count + t_cnt'(1);
                                n_out_count = r_count + t_cnt'(1);
                            end
                        end
                        REQ_QUERY: begin
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_q         = w_time_value;
                                n_first     = '0;
                                n_len       = r_count;
                                n_state     = S_PROBE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (r_len != '0) begin
                    // probe the middle of the remaining range
                    w_rd_en = 1'b1;
                    n_half  = r_len >> 1;
                    n_state = S_CMP;
                end else if (r_first == r_count) begin
                    // past every entry: take the last one
                    n_sel   = r_count - t_cnt'(1);
                    n_state = S_READ_SEL;
                end else if (r_first == '0) begin
                    n_sel   = '0;
                    n_state = S_READ_SEL;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_first[ADDR_W-1:0];
                    n_state   = S_DIST_HI;
                end
            end
            S_CMP: begin
                if (w_cmp_lt) begin
                    n_first = r_first + r_half + t_cnt'(1);
                    n_len   = r_len - r_half - t_cnt'(1);
                end else begin
                    n_len = r_half;
                end
                n_state = S_PROBE;
            end
            S_DIST_HI: begin
                n_dist_hi = w_cmp_diff;
                w_rd_en   = 1'b1;
                w_rd_addr = w_first_m1[ADDR_W-1:0];
                n_state   = S_DIST_LO;
            end
            S_DIST_LO: begin
                n_dist_lo = w_cmp_diff;
                n_state   = S_PICK;
            end
            S_PICK: begin
                // strictly nearer upper candidate wins, ties go to the predecessor
                n_sel   = w_cmp_lt ? r_first : w_first_m1;
                n_state = S_READ_SEL;
            end
            S_READ_SEL: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_sel[ADDR_W-1:0];
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                // output register was left empty when the query was taken
                n_out_valid   = 1'b1;
                n_out_status  = ST_OK;
                n_out_time    = w_rd_time;
                n_out_payload = w_rd_payload;
                n_out_count   = r_count;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q           <= n_q;
        r_first       <= n_first;
        r_len         <= n_len;
        r_half        <= n_half;
        r_sel         <= n_sel;
        r_dist_hi     <= n_dist_hi;
        r_dist_lo     <= n_dist_lo;
        r_out_status  <= n_out_status;
        r_out_time    <= n_out_time;
        r_out_payload <= n_out_payload;
        r_out_count   <= n_out_count;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {5'd0, r_out_count, r_out_payload, r_out_time};

endmodule
